// ===== rtl/assert_macros.svh =====
// Assertion helpers used by the tree unit RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge, including during reset.
`define RLMT_ASSERT(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) else $error("assertion failed");

// Checked on rising edges while the active-low reset is released.
`define RLMT_ASSERT_RST(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");

`endif

// ===== rtl/rlmt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlmt_pkg
// Shared constants and the node word layout of the range minimum tree.
// ----------------------------------------------------------------------------
package rlmt_pkg;

    localparam int LEAVES     = 1024;
    localparam int LEAVES_LOG = $clog2(LEAVES);
    localparam int NODE_AW    = LEAVES_LOG + 1;
    localparam int POS_W      = LEAVES_LOG + 2;
    localparam int LEV_W      = $clog2(LEAVES_LOG + 1);
    localparam int VAL_W      = 31;
    localparam int IDX_W      = 10;
    localparam int S_DATA_W   = 56;
    localparam int M_DATA_W   = 32;

    localparam logic [VAL_W-1:0] TOP_VALUE = {VAL_W{1'b1}};

    typedef enum logic {
        CMD_ASSIGN = 1'b0,
        CMD_QUERY  = 1'b1
    } cmd_t;

    typedef struct packed {
        logic             tag;
        logic [VAL_W-1:0] tag_val;
        logic [VAL_W-1:0] min_val;
    } node_t;

    localparam int NODE_W = $bits(node_t);

endpackage

// ===== rtl/range_assign_range_min_tree_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// range_assign_range_min_tree_unit
// Range assign and range minimum over LEAVES slots held in a lazy tree.
// ----------------------------------------------------------------------------
// One item is handled at a time. Every tree node sits in a single RAM word
// (minimum, pending mark and pending value), and each node visit is one RAM
// access with a registered read. On the two boundary paths a marked node is
// read, both its children are written and it is written back, an unmarked
// node is read and written back, and a level and side with no boundary node
// is passed over. The middle pass reads each covered node for a query or
// writes it for an assign. An assign then reads both children of each
// boundary node on the way up and writes it back. After reset the 2 * LEAVES
// RAM words are swept once before the first beat is taken. Results go out
// through a register; a held query result does not block an assign behind it.
module range_assign_range_min_tree_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // command[0], range_lo[10:1], range_hi[20:11], value[51:21]
    input  logic [rlmt_pkg::S_DATA_W-1:0] s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // minimum[30:0]
    output logic [rlmt_pkg::M_DATA_W-1:0] m_tdata
);
    import rlmt_pkg::*;
    `include "assert_macros.svh"

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_PUSH_SEL, ST_PUSH_CHK, ST_PUSH_W1, ST_PUSH_W2,
        ST_PUSH_W3, ST_LOOP, ST_LOOP_RD, ST_UPD_SEL, ST_UPD_RB, ST_UPD_WR, ST_DONE
    } state_t;

    state_t             state_reg;
    logic [NODE_AW-1:0] clr_reg;
    logic [POS_W-1:0]   l_reg, r_reg, l2_reg, r2_reg;
    logic [LEV_W-1:0]   lev_reg;
    logic               side_reg;
    logic [NODE_AW-1:0] k_reg;
    logic [VAL_W-1:0]   tagv_reg, tmp_reg, acc_reg, val_reg;
    logic               query_reg;
    logic               out_valid_reg;
    logic [VAL_W-1:0]   out_min_reg;

    logic               mem_we;
    logic [NODE_AW-1:0] mem_waddr, mem_raddr;
    node_t              mem_wdata, rd_node;
    logic [NODE_W-1:0]  rd_raw;

    logic               in_cmd;
    logic [IDX_W-1:0]   in_lo, in_hi;
    logic [VAL_W-1:0]   in_val;
    logic [IDX_W:0]     hi_plus;
    logic [POS_W-1:0]   in_l, in_r;

    logic [POS_W-1:0]   cur_x, lev_mask, r_dec, r2_dec, tgt;
    logic               bnd;
    logic [NODE_AW-1:0] node_k;
    logic               tgt_hit;

    assign in_cmd  = s_tdata[0];
    assign in_lo   = s_tdata[10:1];
    assign in_hi   = s_tdata[20:11];
    assign in_val  = s_tdata[51:21];
    assign hi_plus = {1'b0, in_hi} + (IDX_W+1)'(1);
    assign in_l    = POS_W'(in_lo) + POS_W'(LEAVES);
    assign in_r    = (POS_W'(hi_plus) > POS_W'(LEAVES)) ? POS_W'(2 * LEAVES)
                                                      : POS_W'(hi_plus) + POS_W'(LEAVES);

    assign cur_x    = side_reg ? r_reg : l_reg;
    assign lev_mask = ~({POS_W{1'b1}} << lev_reg);
    assign bnd      = (cur_x & lev_mask) != '0;
    assign r_dec    = r_reg - POS_W'(1);
    assign node_k   = NODE_AW'((side_reg ? r_dec : l_reg) >> lev_reg);
    assign r2_dec   = r2_reg - POS_W'(1);
    assign tgt_hit  = (l2_reg < r2_reg) && (l2_reg[0] || r2_reg[0]);
    assign tgt      = l2_reg[0] ? l2_reg : r2_dec;
    assign rd_node  = node_t'(rd_raw);

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_min_reg};

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = k_reg;
        mem_wdata = '{tag: 1'b0, tag_val: tagv_reg, min_val: tmp_reg};
        mem_raddr = node_k;
        case (state_reg)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = '{tag: 1'b0, tag_val: TOP_VALUE, min_val: TOP_VALUE};
            end
            ST_PUSH_W1, ST_PUSH_W2: begin
                mem_we    = 1'b1;
                mem_waddr = {k_reg[NODE_AW-2:0], (state_reg == ST_PUSH_W2)};
                mem_wdata = '{tag: (lev_reg != LEV_W'(1)), tag_val: tagv_reg,
                              min_val: tagv_reg};
            end
            ST_PUSH_W3: begin
                mem_we = 1'b1;
            end
            ST_LOOP: begin
                mem_we    = !query_reg && tgt_hit;
                mem_waddr = NODE_AW'(tgt);
                mem_raddr = NODE_AW'(tgt);
                mem_wdata = '{tag: !tgt[LEAVES_LOG], tag_val: val_reg, min_val: val_reg};
            end
            ST_UPD_SEL: begin
                mem_raddr = {node_k[NODE_AW-2:0], 1'b0};
            end
            ST_UPD_RB: begin
                mem_raddr = {k_reg[NODE_AW-2:0], 1'b1};
            end
            ST_UPD_WR: begin
                mem_we    = 1'b1;
                mem_wdata = '{tag: 1'b0, tag_val: tagv_reg,
                              min_val: (rd_node.min_val < tmp_reg) ? rd_node.min_val
                                                                   : tmp_reg};
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    rlmt_node_ram #(
        .DATA_W (NODE_W),
        .ADDR_W (NODE_AW)
    ) u_node_ram (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_addr (mem_raddr),
        .rd_data (rd_raw)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (out_valid_reg && m_tready && state_reg != ST_DONE) begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_CLEAR: begin
                    clr_reg <= clr_reg + NODE_AW'(1);
                    if (clr_reg == {NODE_AW{1'b1}}) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (s_tvalid) begin
                        query_reg <= (in_cmd == CMD_QUERY);
                        val_reg   <= in_val;
                        acc_reg   <= TOP_VALUE;
                        l_reg     <= in_l;
                        r_reg     <= in_r;
                        l2_reg    <= in_l;
                        r2_reg    <= in_r;
                        lev_reg   <= LEV_W'(LEAVES_LOG);
                        side_reg  <= 1'b0;
                        if (in_l >= in_r) begin
                            state_reg <= (in_cmd == CMD_QUERY) ? ST_DONE : ST_IDLE;
                        end else begin
                            state_reg <= ST_PUSH_SEL;
                        end
                    end
                end
                ST_PUSH_SEL: begin
                    k_reg <= node_k;
                    if (bnd) begin
                        state_reg <= ST_PUSH_CHK;
                    end else begin
                        side_reg <= !side_reg;
                        if (side_reg) begin
                            if (lev_reg == LEV_W'(1)) begin
                                state_reg <= ST_LOOP;
                            end else begin
                                lev_reg <= lev_reg - LEV_W'(1);
                            end
                        end
                    end
                end
                ST_PUSH_CHK: begin
                    tagv_reg <= rd_node.tag_val;
                    tmp_reg  <= rd_node.min_val;
                    if (rd_node.tag) begin
                        state_reg <= ST_PUSH_W1;
                    end else begin
                        state_reg <= ST_PUSH_W3;
                    end
                end
                ST_PUSH_W1: state_reg <= ST_PUSH_W2;
                ST_PUSH_W2: state_reg <= ST_PUSH_W3;
                ST_PUSH_W3: begin
                    state_reg <= ST_PUSH_SEL;
                    side_reg  <= !side_reg;
                    if (side_reg) begin
                        if (lev_reg == LEV_W'(1)) begin
                            state_reg <= ST_LOOP;
                        end else begin
                            lev_reg <= lev_reg - LEV_W'(1);
                        end
                    end
                end
                ST_LOOP: begin
                    if (l2_reg >= r2_reg) begin
                        lev_reg   <= LEV_W'(1);
                        side_reg  <= 1'b0;
                        state_reg <= query_reg ? ST_DONE : ST_UPD_SEL;
                    end else if (l2_reg[0]) begin
                        l2_reg <= l2_reg + POS_W'(1);
                        if (query_reg) begin
                            state_reg <= ST_LOOP_RD;
                        end
                    end else if (r2_reg[0]) begin
                        r2_reg <= r2_dec;
                        if (query_reg) begin
                            state_reg <= ST_LOOP_RD;
                        end
                    end else begin
                        l2_reg <= l2_reg >> 1;
                        r2_reg <= r2_reg >> 1;
                    end
                end
                ST_LOOP_RD: begin
                    if (rd_node.min_val < acc_reg) begin
                        acc_reg <= rd_node.min_val;
                    end
                    state_reg <= ST_LOOP;
                end
                ST_UPD_SEL: begin
                    k_reg <= node_k;
                    if (bnd) begin
                        state_reg <= ST_UPD_RB;
                    end else begin
                        side_reg <= !side_reg;
                        if (side_reg) begin
                            if (lev_reg == LEV_W'(LEAVES_LOG)) begin
                                state_reg <= ST_IDLE;
                            end else begin
                                lev_reg <= lev_reg + LEV_W'(1);
                            end
                        end
                    end
                end
                ST_UPD_RB: begin
                    tmp_reg   <= rd_node.min_val;
                    state_reg <= ST_UPD_WR;
                end
                ST_UPD_WR: begin
                    state_reg <= ST_UPD_SEL;
                    side_reg  <= !side_reg;
                    if (side_reg) begin
                        if (lev_reg == LEV_W'(LEAVES_LOG)) begin
                            state_reg <= ST_IDLE;
                        end else begin
                            lev_reg <= lev_reg + LEV_W'(1);
                        end
                    end
                end
                ST_DONE: begin
                    if (!out_valid_reg || m_tready) begin
                        out_valid_reg <= 1'b1;
                        out_min_reg   <= acc_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    `RLMT_ASSERT(a_reset_clears_out, aclk, !aresetn |=> !m_tvalid)
    `RLMT_ASSERT_RST(a_clear_blocks_input, aclk, aresetn,
        (state_reg == ST_CLEAR) |-> !s_tready)
    `RLMT_ASSERT_RST(a_result_from_query, aclk, aresetn,
        $rose(m_tvalid) |-> $past(query_reg))
    `RLMT_ASSERT_RST(a_no_root_zero_write, aclk, aresetn,
        (mem_we && state_reg != ST_CLEAR) |-> (mem_waddr != '0))

endmodule

// ===== rtl/rlmt_node_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlmt_node_ram
// Simple dual-port synchronous RAM with one write and one registered read.
// ----------------------------------------------------------------------------
module rlmt_node_ram #(
    parameter int DATA_W = 8,
    parameter int ADDR_W = 4
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [2**ADDR_W];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== tb/tb_range_assign_range_min_tree_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_range_assign_range_min_tree_unit
// Self-checking bench for the range assign / range minimum tree.
// ----------------------------------------------------------------------------
// Commands are queued by an initial block and presented by a clocked driver.
// A predictor holds a flat array of slot values. It applies each accepted
// assign and computes the minimum for each accepted query, and it stores the
// expected minimum. The monitor compares every result beat against the oldest
// stored minimum. Idle cycles on the input and output sides change between
// phases, and one long output stall makes the block hold off new beats.
// ----------------------------------------------------------------------------
module tb_range_assign_range_min_tree_unit;
    import rlmt_pkg::*;

    localparam int NUM_SLOTS = 1024;

    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic [IDX_W-1:0] range_hi;
        logic [IDX_W-1:0] range_lo;
        cmd_t             command;
    } tree_cmd_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;

    tree_cmd_t        pending_cmds[$];
    logic [VAL_W-1:0] expected_minima[$];
    logic [VAL_W-1:0] slot_value[NUM_SLOTS];
    int               mismatch_count = 0;
    int               send_idle_pct = 16;
    int               recv_idle_pct = 60;
    bit               recv_hold = 1'b0;
    bit               stim_done = 1'b0;

    always #4 aclk = ~aclk;

    range_assign_range_min_tree_unit uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready),
        // command[0], range_lo[10:1], range_hi[20:11], value[51:21]
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready),
        // minimum[30:0]
        .m_tdata(m_tdata)
    );

    // Updates the slot array and queues the range minimum for a query.
    function automatic void apply_tree_cmd(tree_cmd_t c);
        logic [VAL_W-1:0] least;
        least = TOP_VALUE;
        for (int i = int'(c.range_lo); i <= int'(c.range_hi); i++) begin
            if (c.command == CMD_ASSIGN) begin
                slot_value[i] = c.value;
            end else if (slot_value[i] < least) begin
                least = slot_value[i];
            end
        end
        if (c.command == CMD_QUERY) begin
            expected_minima.push_back(least);
        end
    endfunction

    function automatic tree_cmd_t make_cmd(cmd_t op, int lo, int hi, logic [VAL_W-1:0] v);
        tree_cmd_t c;
        c.command  = op;
        c.range_lo = IDX_W'(lo);
        c.range_hi = IDX_W'(hi);
        c.value    = v;
        return c;
    endfunction

    function automatic logic [VAL_W-1:0] rand_value();
        case ($urandom_range(0, 3))
            0: return VAL_W'($urandom_range(0, 15));
            1: return TOP_VALUE - VAL_W'($urandom_range(0, 3));
            default: return VAL_W'($urandom);
        endcase
    endfunction

    function automatic tree_cmd_t rand_cmd();
        int lo;
        int hi;
        int span;
        cmd_t op;
        op = ($urandom_range(0, 99) < 45) ? CMD_QUERY : CMD_ASSIGN;
        case ($urandom_range(0, 9))
            0: begin
                lo = $urandom_range(0, 1023);
                hi = $urandom_range(0, 1023);
            end
            1: begin
                lo = $urandom_range(1, 1023);
                hi = $urandom_range(0, lo - 1);
            end
            2, 3, 4: begin
                span = $urandom_range(0, 3);
                lo = $urandom_range(0, 1023 - span);
                hi = lo + span;
            end
            default: begin
                span = $urandom_range(0, 200);
                lo = $urandom_range(0, 1023 - span);
                hi = lo + span;
            end
        endcase
        return make_cmd(op, lo, hi, rand_value());
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (s_tvalid) begin
                apply_tree_cmd(tree_cmd_t'(s_tdata[$bits(tree_cmd_t)-1:0]));
                void'(pending_cmds.pop_front());
            end
            if (pending_cmds.size() > 0
                    && $urandom_range(0, 99) >= send_idle_pct) begin
                s_tvalid <= 1'b1;
                s_tdata  <= S_DATA_W'(pending_cmds[0]);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_minima.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("Unexpected result beat: %0d", m_tdata[VAL_W-1:0]);
                end else if (expected_minima[0] !== m_tdata[VAL_W-1:0]) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("Minimum mismatch: expected %0d, got %0d",
                                 expected_minima[0], m_tdata[VAL_W-1:0]);
                    void'(expected_minima.pop_front());
                end else begin
                    void'(expected_minima.pop_front());
                end
            end
            m_tready <= !recv_hold && ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    task automatic wait_drained();
        while (pending_cmds.size() != 0 || s_tvalid || expected_minima.size() != 0)
            @(posedge aclk);
    endtask

    initial begin
        for (int i = 0; i < NUM_SLOTS; i++)
            slot_value[i] = TOP_VALUE;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        pending_cmds.push_back(make_cmd(CMD_QUERY, 0, 1023, '0));
        pending_cmds.push_back(make_cmd(CMD_QUERY, 5, 4, '0));
        pending_cmds.push_back(make_cmd(CMD_ASSIGN, 0, 1023, TOP_VALUE));
        pending_cmds.push_back(make_cmd(CMD_ASSIGN, 0, 0, '0));
        pending_cmds.push_back(make_cmd(CMD_QUERY, 0, 0, '0));
        pending_cmds.push_back(make_cmd(CMD_ASSIGN, 1023, 1023, 31'd7));
        pending_cmds.push_back(make_cmd(CMD_QUERY, 1, 1023, '0));
        pending_cmds.push_back(make_cmd(CMD_QUERY, 1023, 1023, '0));
        pending_cmds.push_back(make_cmd(CMD_ASSIGN, 900, 100, 31'd1));
        pending_cmds.push_back(make_cmd(CMD_QUERY, 1023, 0, '0));
        pending_cmds.push_back(make_cmd(CMD_QUERY, 0, 1023, '0));
        pending_cmds.push_back(make_cmd(CMD_ASSIGN, 256, 767, 31'h2AAAAAAA));
        pending_cmds.push_back(make_cmd(CMD_ASSIGN, 300, 310, 31'h55555555));
        pending_cmds.push_back(make_cmd(CMD_QUERY, 255, 768, '0));
        pending_cmds.push_back(make_cmd(CMD_QUERY, 1, 1022, '0));
        pending_cmds.push_back(make_cmd(CMD_QUERY, 300, 310, '0));
        pending_cmds.push_back(make_cmd(CMD_ASSIGN, 0, 1023, 31'd123));
        pending_cmds.push_back(make_cmd(CMD_QUERY, 511, 512, '0));
        pending_cmds.push_back(make_cmd(CMD_QUERY, 0, 1023, '0));

        for (int n = 0; n < 350; n++)
            pending_cmds.push_back(rand_cmd());
        wait_drained();
        repeat (200) @(posedge aclk);
        send_idle_pct = 60;
        recv_idle_pct = 16;
        for (int n = 0; n < 350; n++)
            pending_cmds.push_back(rand_cmd());
        wait_drained();
        repeat (200) @(posedge aclk);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (int n = 0; n < 300; n++)
            pending_cmds.push_back(make_cmd(CMD_QUERY, $urandom_range(0, 1023),
                                            1023, '0));
        recv_hold = 1'b1;
        repeat (3000) @(posedge aclk);
        recv_hold = 1'b0;
        for (int n = 0; n < 450; n++)
            pending_cmds.push_back(rand_cmd());
        wait_drained();
        repeat (200) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("Some tests failed");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/rlmt_pkg.sv
rtl/rlmt_node_ram.sv
rtl/range_assign_range_min_tree_unit.sv
tb/tb_range_assign_range_min_tree_unit.sv
